>>> design/bsl_pkg.sv
// Shared types and constants for the bootstrap-loader reply deframer.
`default_nettype none
package bsl_pkg;

	// Reply type bytes that open a reply.
	localparam logic [7:0] TYPE_HDR = 8'h80;
	localparam logic [7:0] TYPE_ACK = 8'h90;
	localparam logic [7:0] TYPE_NAK = 8'hA0;

	// Both checksum accumulators start from this value.
	localparam logic [7:0] CHECK_INIT = 8'hFF;

	// Header, length and checksum bytes that frame the payload.
	localparam int unsigned TRAILER_BYTES = 6;
	// First payload position in a frame.
	localparam int unsigned PAYLOAD_START = 4;

	// Width used for position and length comparisons (holds 255 + 6).
	localparam int unsigned CMP_W = 10;

	// Result kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Verdict codes.
	localparam logic [2:0] ST_NONE     = 3'd0;
	localparam logic [2:0] ST_ACK      = 3'd0;
	localparam logic [2:0] ST_OK       = 3'd1;
	localparam logic [2:0] ST_BAD      = 3'd2;
	localparam logic [2:0] ST_NAK      = 3'd3;
	localparam logic [2:0] ST_UNKNOWN  = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;

	typedef logic [2:0] status_t;

endpackage
`default_nettype wire

>>> design/bsl_rx_if.sv
// Channel interface that carries received serial bytes.
`default_nettype none
interface bsl_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

>>> design/bsl_res_if.sv
// Channel interface that carries deframer results (payload bytes and verdicts).
`default_nettype none
interface bsl_res_if
	import bsl_pkg::*;
;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic [7:0] byte_index;
	status_t    status;
	logic [7:0] frame_len;

	modport source (output valid, output kind, output data_byte, output byte_index,
		output status, output frame_len, input ready);
	modport sink   (input valid, input kind, input data_byte, input byte_index,
		input status, input frame_len, output ready);
endinterface
`default_nettype wire

>>> design/bsl_reply_deframer.sv
// Top level of the bootstrap-loader reply deframer.
// The block takes one received byte per transfer and gives at most one result per byte:
// a payload byte with its index, or a verdict that ends the reply (ack, nak, unknown type,
// checksum good or bad, overflow). Each byte is decoded in the cycle it is transferred and
// its result sits in the output register from the next cycle on; while results are taken,
// the block sustains one byte per cycle. The output register is the only stage; a new
// byte is taken whenever that register is empty or is being emptied in the same cycle, so
// the input stalls only while a result waits on the output side.
`default_nettype none
module bsl_reply_deframer
	import bsl_pkg::*;
#(
	parameter int unsigned BUF_BYTES = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bsl_rx_if.sink     rx,
	bsl_res_if.source  res
);

	localparam int unsigned CNT_W = $clog2(BUF_BYTES + 1);

	// Frame state.
	logic             in_frame_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       len_q;
	logic [7:0]       chk_even_q;
	logic [7:0]       chk_odd_q;

	// Output register.
	logic       res_vld_q;
	logic       kind_q;
	logic [7:0] data_q;
	logic [7:0] index_q;
	status_t    status_q;
	logic [7:0] flen_q;

	// Next state and result of the byte on the input.
	logic             in_frame_d;
	logic [CNT_W-1:0] cnt_d;
	logic [7:0]       len_d;
	logic [7:0]       chk_even_d;
	logic [7:0]       chk_odd_d;
	logic             has_res;
	logic             kind_d;
	logic [7:0]       data_d;
	logic [7:0]       index_d;
	status_t          status_d;
	logic [7:0]       flen_d;

	logic             rx_xfer;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic [CMP_W-1:0] len_w;
	logic             end_hit;
	logic             ovf_hit;
	logic             pay_hit;

	assign rx.ready = !res_vld_q || res.ready;
	assign rx_xfer  = rx.valid && rx.ready;

	// Decode one byte against the current frame state.
	always_comb begin
		in_frame_d = in_frame_q;
		cnt_d      = cnt_q;
		len_d      = len_q;
		chk_even_d = chk_even_q;
		chk_odd_d  = chk_odd_q;
		has_res    = 1'b0;
		kind_d     = KIND_VERDICT;
		data_d     = 8'd0;
		index_d    = 8'd0;
		status_d   = ST_NONE;
		flen_d     = 8'd0;
		pos_w      = CMP_W'(cnt_q);
		cnt_w      = '0;
		len_w      = '0;
		end_hit    = 1'b0;
		ovf_hit    = 1'b0;
		pay_hit    = 1'b0;

		if (!in_frame_q) begin
			// First byte of a reply selects its type.
			cnt_d      = '0;
			len_d      = 8'd0;
			chk_even_d = CHECK_INIT;
			chk_odd_d  = CHECK_INIT;
			if (rx.rx_byte == TYPE_ACK) begin
				has_res  = 1'b1;
				status_d = ST_ACK;
			end else if (rx.rx_byte == TYPE_NAK) begin
				has_res  = 1'b1;
				status_d = ST_NAK;
			end else if (rx.rx_byte != TYPE_HDR) begin
				has_res  = 1'b1;
				status_d = ST_UNKNOWN;
			end else begin
				in_frame_d = 1'b1;
				chk_even_d = CHECK_INIT ^ rx.rx_byte;
				cnt_d      = CNT_W'(1);
			end
		end else begin
			// Accumulate checksums and capture the length byte.
			if (cnt_q[0]) begin
				chk_odd_d = chk_odd_q ^ rx.rx_byte;
			end else begin
				chk_even_d = chk_even_q ^ rx.rx_byte;
			end
			if (pos_w == CMP_W'(2)) begin
				len_d = rx.rx_byte;
			end
			cnt_d = cnt_q + CNT_W'(1);
			cnt_w = CMP_W'(cnt_d);
			len_w = CMP_W'(len_d);

			end_hit = (cnt_w >= CMP_W'(TRAILER_BYTES)) &&
				(cnt_w == len_w + CMP_W'(TRAILER_BYTES));
			ovf_hit = cnt_w >= CMP_W'(BUF_BYTES);
			pay_hit = (pos_w >= CMP_W'(PAYLOAD_START)) &&
				(pos_w <= len_w + CMP_W'(PAYLOAD_START - 1));

			flen_d = len_d;
			if (end_hit || ovf_hit) begin
				// The frame ends: report and return to idle.
				has_res    = 1'b1;
				status_d   = end_hit ?
					((chk_even_d == 8'd0 && chk_odd_d == 8'd0) ? ST_OK : ST_BAD) :
					ST_OVERFLOW;
				in_frame_d = 1'b0;
				cnt_d      = '0;
				len_d      = 8'd0;
				chk_even_d = CHECK_INIT;
				chk_odd_d  = CHECK_INIT;
			end else if (pay_hit) begin
				has_res = 1'b1;
				kind_d  = KIND_PAYLOAD;
				data_d  = rx.rx_byte;
				index_d = pos_w[7:0] - 8'(PAYLOAD_START);
			end
		end
	end

	// Frame state advances on each input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			cnt_q      <= '0;
			len_q      <= 8'd0;
			chk_even_q <= CHECK_INIT;
			chk_odd_q  <= CHECK_INIT;
		end else if (rx_xfer) begin
			in_frame_q <= in_frame_d;
			cnt_q      <= cnt_d;
			len_q      <= len_d;
			chk_even_q <= chk_even_d;
			chk_odd_q  <= chk_odd_d;
		end
	end

	// Output valid fills on a result and drains on an output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (rx.ready) begin
			res_vld_q <= rx_xfer && has_res;
		end
	end

	// Output payload loads with each new result.
	always_ff @(posedge clk) begin
		if (rx_xfer && has_res) begin
			kind_q   <= kind_d;
			data_q   <= data_d;
			index_q  <= index_d;
			status_q <= status_d;
			flen_q   <= flen_d;
		end
	end

	assign res.valid      = res_vld_q;
	assign res.kind       = kind_q;
	assign res.data_byte  = data_q;
	assign res.byte_index = index_q;
	assign res.status     = status_q;
	assign res.frame_len  = flen_q;

endmodule
`default_nettype wire

>>> design/bsl_checker.sv
// Port-level checks for the reply deframer and the bind that attaches them.
`default_nettype none
module bsl_checker
	import bsl_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rx_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic       res_kind,
	input wire logic [7:0] res_data_byte,
	input wire logic [7:0] res_byte_index,
	input wire logic [2:0] res_status,
	input wire logic [7:0] frame_len
);

	// A stalled result holds until it is transferred.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind) &&
		$stable(res_data_byte) && $stable(res_byte_index) && $stable(res_status) &&
		$stable(frame_len))
		else $error("result changed while stalled");

	// With the output register empty, the block takes a byte.
	a_rx_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> rx_ready)
		else $error("input stalled with an empty output register");

	// A payload result carries no verdict code.
	a_pay_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_PAYLOAD |-> res_status == ST_NONE)
		else $error("payload result with a verdict code");

	// Replies that are not data frames report no length and no payload fields.
	a_short_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_VERDICT &&
		(res_status == ST_ACK || res_status == ST_NAK || res_status == ST_UNKNOWN)
		|-> frame_len == 8'd0 && res_data_byte == 8'd0 && res_byte_index == 8'd0)
		else $error("short verdict with nonzero fields");

	// Verdict codes stay within the defined set.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_VERDICT |-> res_status <= ST_OVERFLOW)
		else $error("verdict code out of range");

endmodule

bind bsl_reply_deframer bsl_checker u_bsl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rx_ready       (rx.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_kind       (res.kind),
	.res_data_byte  (res.data_byte),
	.res_byte_index (res.byte_index),
	.res_status     (res.status),
	.frame_len      (res.frame_len)
);
`default_nettype wire

>>> sim/bsl_reply_checker.sv
// Checker for the reply deframer: predicts each result from the accepted bytes and compares.
module bsl_reply_checker
	import bsl_pkg::*;
#(
	parameter int unsigned BUF_BYTES = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	bsl_rx_if        rx,
	bsl_res_if       res,
	output int       fail_count,
	output int       pending,
	output int       n_payload,
	output int       n_frames_ok,
	output int       n_frames_bad,
	output int       n_overflow,
	output int       n_short
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		status_t    status;
		logic [7:0] frame_len;
	} reply_t;

	// Deframer state as the predictor tracks it.
	logic       in_frame;
	logic [8:0] rcv_count;
	logic [7:0] len_field;
	logic [7:0] sum_even;
	logic [7:0] sum_odd;

	reply_t expected_replies[$];

	assign pending = expected_replies.size();

	function automatic void clear_frame();
		in_frame  = 1'b0;
		rcv_count = '0;
		len_field = '0;
		sum_even  = CHECK_INIT;
		sum_odd   = CHECK_INIT;
	endfunction

	// Advances the predicted state by one byte; returns 1 when the byte yields a result.
	function automatic bit deframe_byte(input logic [7:0] b, output reply_t r);
		int pos;
		int len;
		r = '0;
		// Idle: the byte is a reply type.
		if (!in_frame) begin
			clear_frame();
			r.kind = KIND_VERDICT;
			if (b == TYPE_ACK) begin
				r.status = ST_ACK;
				return 1'b1;
			end
			if (b == TYPE_NAK) begin
				r.status = ST_NAK;
				return 1'b1;
			end
			if (b != TYPE_HDR) begin
				r.status = ST_UNKNOWN;
				return 1'b1;
			end
			in_frame  = 1'b1;
			sum_even  = sum_even ^ b;
			rcv_count = 9'd1;
			return 1'b0;
		end

		// Inside a frame: accumulate, capture the length and count.
		pos = int'(rcv_count);
		if (rcv_count[0])
			sum_odd = sum_odd ^ b;
		else
			sum_even = sum_even ^ b;
		if (pos == 2)
			len_field = b;
		rcv_count = rcv_count + 9'd1;
		len = int'(len_field);

		// Completion is tested before the buffer limit.
		if (int'(rcv_count) >= int'(TRAILER_BYTES) &&
				int'(rcv_count) == len + int'(TRAILER_BYTES)) begin
			r.kind      = KIND_VERDICT;
			r.status    = (sum_even == 8'h00 && sum_odd == 8'h00) ? ST_OK : ST_BAD;
			r.frame_len = len_field;
			clear_frame();
			return 1'b1;
		end
		if (int'(rcv_count) >= int'(BUF_BYTES)) begin
			r.kind      = KIND_VERDICT;
			r.status    = ST_OVERFLOW;
			r.frame_len = len_field;
			clear_frame();
			return 1'b1;
		end
		if (pos >= int'(PAYLOAD_START) && pos <= len + int'(PAYLOAD_START) - 1) begin
			r.kind       = KIND_PAYLOAD;
			r.data_byte  = b;
			r.byte_index = 8'(pos - int'(PAYLOAD_START));
			r.status     = ST_NONE;
			r.frame_len  = len_field;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		fail_count++;
	endtask

	// Result transfers are checked first, then the byte accepted at the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		reply_t got;
		reply_t want;
		reply_t fresh;
		if (!arst_n) begin
			clear_frame();
			expected_replies.delete();
			fail_count   = 0;
			n_payload    = 0;
			n_frames_ok  = 0;
			n_frames_bad = 0;
			n_overflow   = 0;
			n_short      = 0;
		end else begin
			if (res.valid && res.ready) begin
				got = '{kind: res.kind, data_byte: res.data_byte, byte_index: res.byte_index,
					status: res.status, frame_len: res.frame_len};
				if (expected_replies.size() == 0) begin
					flag_mismatch($sformatf("result with none pending: kind=%0d data=%02h idx=%0d st=%0d len=%0d",
						got.kind, got.data_byte, got.byte_index, got.status, got.frame_len));
				end else begin
					want = expected_replies.pop_front();
					if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
							got.byte_index !== want.byte_index || got.status !== want.status ||
							got.frame_len !== want.frame_len)
						flag_mismatch($sformatf(
							"got kind=%0d data=%02h idx=%0d st=%0d len=%0d, want kind=%0d data=%02h idx=%0d st=%0d len=%0d",
							got.kind, got.data_byte, got.byte_index, got.status, got.frame_len,
							want.kind, want.data_byte, want.byte_index, want.status, want.frame_len));
					if (want.kind == KIND_PAYLOAD)
						n_payload++;
					else if (want.status == ST_OK)
						n_frames_ok++;
					else if (want.status == ST_BAD)
						n_frames_bad++;
					else if (want.status == ST_OVERFLOW)
						n_overflow++;
					else
						n_short++;
				end
			end
			if (rx.valid && rx.ready) begin
				if (deframe_byte(rx.rx_byte, fresh))
					expected_replies.push_back(fresh);
			end
		end
	end

endmodule

>>> sim/bsl_reply_deframer_tb.sv
// Top of the reply deframer testbench: clock, reset, byte stimulus, receiver stalls and verdict.
module bsl_reply_deframer_tb;
	import bsl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned BUF_BYTES   = 256;
	localparam int          BYTE_TARGET = 1450;
	localparam int          HOLD_CYCLES = 400;

	typedef enum {RDY_FREE, RDY_COIN, RDY_CADENCE, RDY_STARVED} ready_style_t;

	logic clk;
	logic arst_n;

	bsl_rx_if  rx_ch();
	bsl_res_if res_ch();

	int fail_count;
	int pending;
	int n_payload;
	int n_frames_ok;
	int n_frames_bad;
	int n_overflow;
	int n_short;

	int bytes_sent;
	int burst_left;
	bit hold_req;

	bsl_reply_deframer #(.BUF_BYTES(BUF_BYTES)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	bsl_reply_checker #(.BUF_BYTES(BUF_BYTES)) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx           (rx_ch),
		.res          (res_ch),
		.fail_count   (fail_count),
		.pending      (pending),
		.n_payload    (n_payload),
		.n_frames_ok  (n_frames_ok),
		.n_frames_bad (n_frames_bad),
		.n_overflow   (n_overflow),
		.n_short      (n_short)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#20_000_000;
		$display("Timeout: run did not finish, %0d results still pending", pending);
		$display("Test completed with failures");
		$finish;
	end

	// Offers one byte, called at a falling edge; returns at the falling edge after the transfer.
	task automatic offer_byte(input logic [7:0] b);
		int gap;
		// Between bursts the sender goes quiet for a while.
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				rx_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ?
				$urandom_range(40, 120) : $urandom_range(1, 24);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// Sends a data frame with the given length; the last two bytes zero both checksums
	// unless a bad checksum is wanted. Frames too long for the buffer stop where it fills.
	task automatic send_frame(input int len, input bit good_sum);
		logic [7:0] acc_even;
		logic [7:0] acc_odd;
		logic [7:0] b;
		int total;
		acc_even = CHECK_INIT;
		acc_odd  = CHECK_INIT;
		total    = len + int'(TRAILER_BYTES);
		if (total > int'(BUF_BYTES))
			total = int'(BUF_BYTES);
		for (int p = 0; p < total; p++) begin
			if (p == 0)
				b = TYPE_HDR;
			else if (p == 2)
				b = len[7:0];
			else if (p >= len + int'(PAYLOAD_START))
				b = p[0] ? acc_odd : acc_even;
			else
				b = 8'($urandom_range(0, 255));
			if (!good_sum && p == len + int'(TRAILER_BYTES) - 1)
				b = b ^ 8'(1 << $urandom_range(0, 7));
			if (p[0])
				acc_odd = acc_odd ^ b;
			else
				acc_even = acc_even ^ b;
			offer_byte(b);
		end
	endtask

	// Receiver: a long hold-off on request, otherwise a stall style that changes now and then.
	initial begin : receiver
		int hold_left;
		int style_left;
		int cadence;
		ready_style_t style;
		hold_left  = 0;
		style_left = 0;
		cadence    = 0;
		style      = RDY_FREE;
		res_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			cadence++;
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				res_ch.ready <= 1'b0;
			end else begin
				if (style_left == 0) begin
					style      = ready_style_t'($urandom_range(0, 3));
					style_left = $urandom_range(8, 64);
				end
				style_left--;
				case (style)
					RDY_FREE:    res_ch.ready <= 1'b1;
					RDY_COIN:    res_ch.ready <= 1'($urandom_range(0, 1));
					RDY_CADENCE: res_ch.ready <= (cadence % 3 == 0);
					default:     res_ch.ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// Stimulus and verdict.
	initial begin : stimulus
		int pick;
		int len_sel;
		int iter;
		int drain;
		arst_n        = 1'b0;
		rx_ch.valid   <= 1'b0;
		rx_ch.rx_byte <= 8'h00;
		bytes_sent    = 0;
		burst_left    = 0;
		hold_req      = 1'b0;
		iter          = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: each short reply, the byte extremes, short frames good and bad.
		offer_byte(TYPE_ACK);
		offer_byte(TYPE_NAK);
		offer_byte(8'h00);
		offer_byte(8'hFF);
		send_frame(0, 1'b1);
		send_frame(1, 1'b0);
		send_frame(2, 1'b1);

		// Frame that ends exactly on the last buffer byte, then one that overflows
		// with a payload byte filling the buffer.
		send_frame(int'(BUF_BYTES) - int'(TRAILER_BYTES), 1'b1);
		send_frame(int'(BUF_BYTES) - int'(TRAILER_BYTES) + 2, 1'b1);

		// Random mix: mostly well-formed frames, some short replies and line noise.
		while (bytes_sent < BYTE_TARGET) begin
			if (iter == 6)
				hold_req = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len_sel = $urandom_range(0, 99);
				if (len_sel < 80)
					send_frame($urandom_range(0, 12), $urandom_range(0, 3) != 0);
				else if (len_sel < 97)
					send_frame($urandom_range(13, 64), $urandom_range(0, 3) != 0);
				else
					send_frame($urandom_range(200, 255), $urandom_range(0, 3) != 0);
			end else if (pick < 80) begin
				offer_byte($urandom_range(0, 1) ? TYPE_ACK : TYPE_NAK);
			end else begin
				offer_byte(8'($urandom_range(0, 255)));
			end
			iter++;
		end
		rx_ch.valid <= 1'b0;

		// Drain outstanding results, then let the output stage settle before the verdict.
		drain = 0;
		while (pending != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);

		if (pending != 0)
			$display("%0d expected results never arrived", pending);
		$display("Run covered %0d bytes: %0d payload bytes, %0d good frames, %0d bad checksums",
			bytes_sent, n_payload, n_frames_ok, n_frames_bad);
		$display("plus %0d overflows and %0d ack/nak/unknown replies, with one %0d-cycle hold-off",
			n_overflow, n_short, HOLD_CYCLES);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
